// ===== src/fedd_pkg.sv =====
// Shared types, codes and constants for the fault event debounce block.
`timescale 1ns / 1ps
package fedd_pkg;

    localparam int EVENT_COUNT_DEF = 32;
    localparam int SLOT_COUNT_DEF  = 16;

    localparam logic [7:0] CONFIRM_OCC = 8'd2;

    // Status byte bits
    localparam logic [7:0] ST_TF        = 8'h01;
    localparam logic [7:0] ST_TFTOC     = 8'h02;
    localparam logic [7:0] ST_PENDING   = 8'h04;
    localparam logic [7:0] ST_CONFIRMED = 8'h08;
    localparam logic [7:0] ST_TNCSLC    = 8'h10;
    localparam logic [7:0] ST_TFSLC     = 8'h20;
    localparam logic [7:0] ST_TNCTOC    = 8'h40;
    localparam logic [7:0] ST_RESET     = 8'h50;

    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_MAP    = 2'd1,
        OP_AGE    = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REP_PASSED    = 2'd0,
        REP_FAILED    = 2'd1,
        REP_PREPASSED = 2'd2,
        REP_PREFAILED = 2'd3
    } rep_t;

    typedef enum logic [2:0] {
        CFG_PASSED_LIMIT   = 3'd0,
        CFG_FAILED_LIMIT   = 3'd1,
        CFG_STEP_UP        = 3'd2,
        CFG_STEP_DOWN      = 3'd3,
        CFG_OCCURRENCE_CAP = 3'd4,
        CFG_AGING_CAP      = 3'd5,
        CFG_AGING_LIMIT    = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [7:0] passed_limit;
        logic [6:0]        failed_limit;
        logic [6:0]        step_up;
        logic [7:0]        step_down;
        logic [7:0]        occurrence_cap;
        logic [7:0]        aging_cap;
        logic [7:0]        aging_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] occ;
        logic [7:0] aging;
        logic       aged;
    } slot_rec_t;

endpackage

// ===== src/fault_event_debounce_dtc_status.sv =====
// Top level: event debounce table, trouble-code slot table and sequencer.
//
//  channel | signals                                           | direction
//  in      | in_valid, in_stall, opcode, event_id,             | item in
//          | event_report, slot_index                          |
//  out     | out_valid, out_stall, ok, status_byte,            | result out
//          | fault_detection, occurrences, aged_out            |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data         | register write
//
// Report: accept, event table, slot update, result; no update if rejected or unmapped.
// Map and read: accept, execute, slot read, result; no read if rejected or no slot.
// Aging: one slot per cycle through the shared slot unit, then the result.
// One word at a time: in_stall is high from accept until the result is taken.
// Reset clears all tables to their start values at once; cfg_ready is always high.
`timescale 1ns / 1ps
module fault_event_debounce_dtc_status #(
    parameter int EVENT_COUNT = fedd_pkg::EVENT_COUNT_DEF,
    parameter int SLOT_COUNT  = fedd_pkg::SLOT_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [5:0]        event_id,
    input  logic [1:0]        event_report,
    input  logic [4:0]        slot_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              ok,
    output logic [7:0]        status_byte,
    output logic signed [7:0] fault_detection,
    output logic [7:0]        occurrences,
    output logic              aged_out,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import fedd_pkg::*;

    localparam int EV_AW   = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;
    localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MAP_W   = ($clog2(SLOT_COUNT + 1) > 5) ? $clog2(SLOT_COUNT + 1) : 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SLOT,
        S_RDSLOT,
        S_AGE,
        S_OUT
    } state_t;

    state_t            state_reg;
    op_t               op_reg;
    logic [5:0]        id_reg;
    rep_t              rep_reg;
    logic [4:0]        slot_in_reg;
    logic [SLOT_AW-1:0] addr_reg;
    cfg_t              cfg_reg;

    logic              res_ok_reg;
    logic [7:0]        res_st_reg;
    logic signed [7:0] res_fd_reg;
    logic [7:0]        res_occ_reg;
    logic              res_aged_reg;

    logic signed [7:0] dbv_reg [EVENT_COUNT];
    logic [MAP_W-1:0]  map_reg [EVENT_COUNT];
    slot_rec_t         slot_reg [SLOT_COUNT];

    logic              id_ok;
    logic [5:0]        id_m1;
    logic [EV_AW-1:0]  ev_idx;
    logic [MAP_W-1:0]  map_cur;
    logic              mapped;
    logic [MAP_W-1:0]  slot_ext;
    logic              map_ok;
    logic              read_ok;
    logic signed [7:0] dbv_cur;
    logic signed [7:0] dbv_new;
    slot_rec_t         slot_cur;
    slot_rec_t         slot_new;
    logic              age_mode;
    logic              dbv_we;
    logic              map_we;
    logic              slot_we;

    // Decode the held item
    assign id_ok    = (id_reg >= 6'd1) && ({2'b00, id_reg} <= 8'(EVENT_COUNT));
    assign id_m1    = id_reg - 6'd1;
    assign ev_idx   = id_m1[EV_AW-1:0];
    assign dbv_cur  = dbv_reg[ev_idx];
    assign map_cur  = map_reg[ev_idx];
    assign mapped   = map_cur < MAP_W'(SLOT_COUNT);
    assign slot_ext = MAP_W'(slot_in_reg);
    assign map_ok   = id_ok && (slot_ext <= MAP_W'(SLOT_COUNT));
    assign read_ok  = slot_ext < MAP_W'(SLOT_COUNT);
    assign slot_cur = slot_reg[addr_reg];
    assign age_mode = (state_reg == S_AGE);

    fedd_dbnc u_dbnc (
        .cfg (cfg_reg),
        .rep (rep_reg),
        .cur (dbv_cur),
        .nxt (dbv_new)
    );

    fedd_slot_unit u_slot (
        .cfg      (cfg_reg),
        .age_mode (age_mode),
        .value    (res_fd_reg),
        .cur      (slot_cur),
        .nxt      (slot_new)
    );

    // Table write enables
    assign dbv_we  = (state_reg == S_EXEC) && (op_reg == OP_REPORT) && id_ok && mapped;
    assign map_we  = (state_reg == S_EXEC) && (op_reg == OP_MAP) && map_ok;
    assign slot_we = (state_reg == S_SLOT) || (state_reg == S_AGE);

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.passed_limit   <= -8'sd128;
            cfg_reg.failed_limit   <= 7'd127;
            cfg_reg.step_up        <= 7'd1;
            cfg_reg.step_down      <= 8'd1;
            cfg_reg.occurrence_cap <= 8'd255;
            cfg_reg.aging_cap      <= 8'd255;
            cfg_reg.aging_limit    <= 8'd40;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PASSED_LIMIT:   cfg_reg.passed_limit   <= cfg_data;
                CFG_FAILED_LIMIT:   cfg_reg.failed_limit   <= cfg_data[6:0];
                CFG_STEP_UP:        cfg_reg.step_up        <= cfg_data[6:0];
                CFG_STEP_DOWN:      cfg_reg.step_down      <= cfg_data;
                CFG_OCCURRENCE_CAP: cfg_reg.occurrence_cap <= cfg_data;
                CFG_AGING_CAP:      cfg_reg.aging_cap      <= cfg_data;
                CFG_AGING_LIMIT:    cfg_reg.aging_limit    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Event tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < EVENT_COUNT; i++)
            begin
                dbv_reg[i] <= 8'sd0;
                map_reg[i] <= MAP_W'(SLOT_COUNT);
            end
        end
        else
        begin
            if (dbv_we)
                dbv_reg[ev_idx] <= dbv_new;
            if (map_we)
                map_reg[ev_idx] <= slot_ext;
        end
    end

    // Slot table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                slot_reg[i] <= '{status: ST_RESET, occ: 8'd0, aging: 8'd0, aged: 1'b0};
        end
        else if (slot_we)
        begin
            slot_reg[addr_reg] <= slot_new;
        end
    end

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_REPORT;
            rep_reg      <= REP_PASSED;
            id_reg       <= 6'd0;
            slot_in_reg  <= 5'd0;
            addr_reg     <= '0;
            res_ok_reg   <= 1'b0;
            res_st_reg   <= 8'd0;
            res_fd_reg   <= 8'sd0;
            res_occ_reg  <= 8'd0;
            res_aged_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg      <= op_t'(opcode);
                        id_reg      <= event_id;
                        rep_reg     <= rep_t'(event_report);
                        slot_in_reg <= slot_index;
                        state_reg   <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_ok_reg   <= 1'b0;
                    res_st_reg   <= 8'd0;
                    res_fd_reg   <= 8'sd0;
                    res_occ_reg  <= 8'd0;
                    res_aged_reg <= 1'b0;
                    state_reg    <= S_OUT;
                    case (op_reg)
                        OP_REPORT:
                        begin
                            if (id_ok)
                            begin
                                res_ok_reg <= 1'b1;
                                res_fd_reg <= mapped ? dbv_new : dbv_cur;
                                if (mapped)
                                begin
                                    addr_reg  <= map_cur[SLOT_AW-1:0];
                                    state_reg <= S_SLOT;
                                end
                            end
                        end
                        OP_MAP:
                        begin
                            if (map_ok)
                            begin
                                res_ok_reg <= 1'b1;
                                res_fd_reg <= dbv_cur;
                                if (read_ok)
                                begin
                                    addr_reg  <= slot_ext[SLOT_AW-1:0];
                                    state_reg <= S_RDSLOT;
                                end
                            end
                        end
                        OP_AGE:
                        begin
                            res_ok_reg <= 1'b1;
                            addr_reg   <= '0;
                            state_reg  <= S_AGE;
                        end
                        OP_READ:
                        begin
                            if (read_ok)
                            begin
                                res_ok_reg <= 1'b1;
                                addr_reg   <= slot_ext[SLOT_AW-1:0];
                                state_reg  <= S_RDSLOT;
                            end
                        end
                        default: ;
                    endcase
                end
                S_SLOT:
                begin
                    res_st_reg   <= slot_new.status;
                    res_occ_reg  <= slot_new.occ;
                    res_aged_reg <= slot_new.aged;
                    state_reg    <= S_OUT;
                end
                S_RDSLOT:
                begin
                    res_st_reg   <= slot_cur.status;
                    res_occ_reg  <= slot_cur.occ;
                    res_aged_reg <= slot_cur.aged;
                    state_reg    <= S_OUT;
                end
                S_AGE:
                begin
                    // Advance one slot a cycle until the last
                    if (addr_reg == SLOT_AW'(SLOT_COUNT - 1))
                        state_reg <= S_OUT;
                    else
                        addr_reg <= addr_reg + 1'b1;
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = (state_reg == S_OUT);
    assign cfg_ready       = 1'b1;
    assign ok              = res_ok_reg;
    assign status_byte     = res_st_reg;
    assign fault_detection = res_fd_reg;
    assign occurrences     = res_occ_reg;
    assign aged_out        = res_aged_reg;

    // A result word never shows while a new word can enter
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    // An accepted word is not answered in the next cycle
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid)
        else $error("result appeared too early");

    // A rejected word carries only zero fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (status_byte == 8'd0 && fault_detection == 8'sd0
                                && occurrences == 8'd0 && !aged_out))
        else $error("rejected result carries data");

    // Slot table is written only while a slot or aging step is active
    a_slot_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        slot_we |-> (state_reg == S_SLOT || state_reg == S_AGE))
        else $error("slot write outside update");

endmodule

// ===== src/fedd_dbnc.sv =====
// Debounce counter step: jump or saturating step toward the limits.
`timescale 1ns / 1ps
module fedd_dbnc (
    input  fedd_pkg::cfg_t     cfg,
    input  fedd_pkg::rep_t     rep,
    input  logic signed [7:0]  cur,
    output logic signed [7:0]  nxt
);
    import fedd_pkg::*;

    logic signed [9:0] cur_w;
    logic signed [9:0] pl_w;
    logic signed [9:0] fl_w;
    logic signed [9:0] dn_w;
    logic signed [9:0] up_w;
    logic signed [9:0] res_w;

    // Widen operands so no step can wrap
    assign cur_w = {{2{cur[7]}}, cur};
    assign pl_w  = {{2{cfg.passed_limit[7]}}, cfg.passed_limit};
    assign fl_w  = {3'b000, cfg.failed_limit};
    assign dn_w  = cur_w - {2'b00, cfg.step_down};
    assign up_w  = cur_w + {3'b000, cfg.step_up};

    // Select the new value
    always_comb
    begin
        case (rep)
            REP_PASSED:    res_w = pl_w;
            REP_FAILED:    res_w = fl_w;
            REP_PREPASSED:
            begin
                if (cur_w > pl_w)
                    res_w = (dn_w < pl_w) ? pl_w : dn_w;
                else
                    res_w = cur_w;
            end
            REP_PREFAILED:
            begin
                if (cur_w < fl_w)
                    res_w = (up_w > fl_w) ? fl_w : up_w;
                else
                    res_w = cur_w;
            end
            default:       res_w = cur_w;
        endcase
    end

    assign nxt = res_w[7:0];

endmodule

// ===== src/fedd_slot_unit.sv =====
// Shared slot record update: report qualification or one aging step.
`timescale 1ns / 1ps
module fedd_slot_unit (
    input  fedd_pkg::cfg_t      cfg,
    input  logic                age_mode,
    input  logic signed [7:0]   value,
    input  fedd_pkg::slot_rec_t cur,
    output fedd_pkg::slot_rec_t nxt
);
    import fedd_pkg::*;

    logic signed [8:0] v_w;
    logic signed [8:0] pl_w;
    logic signed [8:0] fl_w;
    logic [7:0]        occ_inc;
    logic [7:0]        age_inc;

    assign v_w     = {value[7], value};
    assign pl_w    = {cfg.passed_limit[7], cfg.passed_limit};
    assign fl_w    = {2'b00, cfg.failed_limit};
    assign occ_inc = (cur.occ < cfg.occurrence_cap) ? cur.occ + 8'd1 : cur.occ;
    assign age_inc = (cur.aging < cfg.aging_cap) ? cur.aging + 8'd1 : cur.aging;

    always_comb
    begin
        nxt = cur;
        if (age_mode)
        begin
            // Age a confirmed code that is not failing now
            if ((cur.status & ST_CONFIRMED) != 8'd0 && (cur.status & ST_TF) == 8'd0)
            begin
                nxt.aging = age_inc;
                if (age_inc >= cfg.aging_limit)
                begin
                    nxt.status = cur.status & ~(ST_CONFIRMED | ST_PENDING);
                    nxt.aged   = 1'b1;
                end
            end
        end
        else
        begin
            // Failed qualification wins over passed when both hold
            if (v_w >= fl_w)
            begin
                nxt.status = cur.status | ST_TF | ST_TFTOC | ST_TFSLC | ST_PENDING;
                nxt.occ    = occ_inc;
                if (occ_inc >= CONFIRM_OCC)
                    nxt.status = nxt.status | ST_CONFIRMED;
                nxt.aging  = 8'd0;
                nxt.aged   = 1'b0;
            end
            else if (v_w <= pl_w)
            begin
                nxt.status = cur.status & ~(ST_TF | ST_PENDING);
            end
            nxt.status = nxt.status & ~(ST_TNCTOC | ST_TNCSLC);
        end
    end

endmodule

// ===== verif/fault_event_debounce_dtc_status_tb.sv =====
// Self-checking testbench for the fault event debounce and trouble-code status block.
`timescale 1ns / 1ps
module fault_event_debounce_dtc_status_tb;
    import fedd_pkg::*;

    localparam int NUM_EVENTS = 32;
    localparam int NUM_SLOTS  = 16;

    typedef struct {
        logic       ok;
        logic [7:0] status;
        logic [7:0] fdc;
        logic [7:0] occ;
        logic       aged;
    } dtc_word_t;

    // Debounce and status-table predictor with a queue of expected words
    class dtc_scoreboard;
        int         errors;
        dtc_word_t  expected_q[$];
        int         passed_lim, failed_lim, step_inc, step_dec;
        int         occ_cap, age_cap, age_lim;
        int         fdc_val[NUM_EVENTS];
        bit         completed[NUM_EVENTS];
        int         slot_of[NUM_EVENTS];
        logic [7:0] status[NUM_SLOTS];
        int         occ_cnt[NUM_SLOTS];
        int         age_cnt[NUM_SLOTS];
        bit         aged[NUM_SLOTS];

        function new();
            errors     = 0;
            passed_lim = -128;
            failed_lim = 127;
            step_inc   = 1;
            step_dec   = 1;
            occ_cap    = 255;
            age_cap    = 255;
            age_lim    = 40;
            for (int i = 0; i < NUM_EVENTS; i++)
            begin
                fdc_val[i]   = 0;
                completed[i] = 0;
                slot_of[i]   = NUM_SLOTS;
            end
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                status[i]  = ST_RESET;
                occ_cnt[i] = 0;
                age_cnt[i] = 0;
                aged[i]    = 0;
            end
        endfunction

        function void write_reg(cfg_idx_t idx, logic [7:0] v);
            case (idx)
                CFG_PASSED_LIMIT:   passed_lim = int'($signed(v));
                CFG_FAILED_LIMIT:   failed_lim = int'(v[6:0]);
                CFG_STEP_UP:        step_inc   = int'(v[6:0]);
                CFG_STEP_DOWN:      step_dec   = int'(v);
                CFG_OCCURRENCE_CAP: occ_cap    = int'(v);
                CFG_AGING_CAP:      age_cap    = int'(v);
                CFG_AGING_LIMIT:    age_lim    = int'(v);
                default: ;
            endcase
        endfunction

        // Apply a qualified debounce value to one slot's status
        function void qualify_slot(int s, int v);
            logic [7:0] st;
            if (s >= NUM_SLOTS)
                return;
            st = status[s];
            if (v >= failed_lim)
            begin
                st = st | ST_TF | ST_TFTOC | ST_TFSLC | ST_PENDING;
                if (occ_cnt[s] < occ_cap)
                    occ_cnt[s]++;
                if (occ_cnt[s] >= int'(CONFIRM_OCC))
                    st = st | ST_CONFIRMED;
                age_cnt[s] = 0;
                aged[s]    = 0;
            end
            else if (v <= passed_lim)
                st = st & ~(ST_TF | ST_PENDING);
            status[s] = st & ~(ST_TNCTOC | ST_TNCSLC);
        endfunction

        function void fill_slot(int s, ref dtc_word_t w);
            if (s < NUM_SLOTS)
            begin
                w.status = status[s];
                w.occ    = occ_cnt[s][7:0];
                w.aged   = aged[s];
            end
        endfunction

        function void note_item(op_t op, int id, rep_t rep, int slot);
            dtc_word_t w;
            bit        id_ok;
            int        e, v;
            w     = '{ok: 0, status: 0, fdc: 0, occ: 0, aged: 0};
            id_ok = (id >= 1) && (id <= NUM_EVENTS);
            e     = id_ok ? id - 1 : 0;
            case (op)
                OP_REPORT:
                    if (id_ok)
                    begin
                        if (slot_of[e] < NUM_SLOTS)
                        begin
                            v = fdc_val[e];
                            case (rep)
                                REP_PASSED:    v = passed_lim;
                                REP_FAILED:    v = failed_lim;
                                REP_PREPASSED:
                                    if (v > passed_lim)
                                    begin
                                        v -= step_dec;
                                        if (v < passed_lim) v = passed_lim;
                                    end
                                default:
                                    if (v < failed_lim)
                                    begin
                                        v += step_inc;
                                        if (v > failed_lim) v = failed_lim;
                                    end
                            endcase
                            fdc_val[e] = v;
                        end
                        completed[e] = 1;
                        qualify_slot(slot_of[e], fdc_val[e]);
                        w.ok  = 1;
                        w.fdc = fdc_val[e][7:0];
                        fill_slot(slot_of[e], w);
                    end
                OP_MAP:
                    if (id_ok && slot <= NUM_SLOTS)
                    begin
                        slot_of[e] = slot;
                        w.ok  = 1;
                        w.fdc = fdc_val[e][7:0];
                        fill_slot(slot, w);
                    end
                OP_AGE:
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if ((status[i] & ST_CONFIRMED) != 0 && (status[i] & ST_TF) == 0)
                        begin
                            if (age_cnt[i] < age_cap)
                                age_cnt[i]++;
                            if (age_cnt[i] >= age_lim)
                            begin
                                status[i] = status[i] & ~(ST_CONFIRMED | ST_PENDING);
                                aged[i]   = 1;
                            end
                        end
                    w.ok = 1;
                end
                default:
                    if (slot < NUM_SLOTS)
                    begin
                        w.ok = 1;
                        fill_slot(slot, w);
                    end
            endcase
            expected_q.push_back(w);
        endfunction

        function void check_result(dtc_word_t got);
            dtc_word_t exp_w;
            if (expected_q.size() == 0)
            begin
                $error("result word with no expectation pending");
                errors++;
                return;
            end
            exp_w = expected_q.pop_front();
            if (got.ok !== exp_w.ok)
            begin
                $error("ok: expected %0d actual %0d", exp_w.ok, got.ok);
                errors++;
            end
            if (got.status !== exp_w.status)
            begin
                $error("status_byte: expected %h actual %h", exp_w.status, got.status);
                errors++;
            end
            if (got.fdc !== exp_w.fdc)
            begin
                $error("fault_detection: expected %0d actual %0d",
                       $signed(exp_w.fdc), $signed(got.fdc));
                errors++;
            end
            if (got.occ !== exp_w.occ)
            begin
                $error("occurrences: expected %0d actual %0d", exp_w.occ, got.occ);
                errors++;
            end
            if (got.aged !== exp_w.aged)
            begin
                $error("aged_out: expected %0d actual %0d", exp_w.aged, got.aged);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              clk          = 0;
    logic              rst_n        = 0;
    logic              in_valid     = 0;
    logic              in_stall;
    logic [1:0]        opcode       = 0;
    logic [5:0]        event_id     = 0;
    logic [1:0]        event_report = 0;
    logic [4:0]        slot_index   = 0;
    logic              out_valid;
    logic              out_stall    = 0;
    logic              ok;
    logic [7:0]        status_byte;
    logic signed [7:0] fault_detection;
    logic [7:0]        occurrences;
    logic              aged_out;
    logic              cfg_valid    = 0;
    logic              cfg_ready;
    logic [2:0]        cfg_index    = 0;
    logic [7:0]        cfg_data     = 0;

    dtc_scoreboard dtc_sb = new();
    int            send_idle_pct  = 0;
    int            stall_pct      = 0;
    int            hold_request   = 0;
    int            hold_left      = 0;

    fault_event_debounce_dtc_status u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .event_id       (event_id),
        .event_report   (event_report),
        .slot_index     (slot_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .status_byte    (status_byte),
        .fault_detection(fault_detection),
        .occurrences    (occurrences),
        .aged_out       (aged_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Drive receiver stall: random, or held for a counted stretch on request
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check every accepted result word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            dtc_sb.check_result('{ok: ok, status: status_byte, fdc: fault_detection,
                                  occ: occurrences, aged: aged_out});
    end

    // Offer one word after a random gap, hold it until accepted
    task automatic send_word(op_t op, int id, rep_t rep, int slot);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 200)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        event_id     <= id[5:0];
        event_report <= rep;
        slot_index   <= slot[4:0];
        do
            @(posedge clk);
        while (in_stall);
        dtc_sb.note_item(op, id, rep, slot);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (dtc_sb.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        dtc_sb.write_reg(idx, v);
    endtask

    task automatic write_all(int pl, int fl, int su, int sd, int oc, int ac, int al);
        write_reg(CFG_PASSED_LIMIT, pl[7:0]);
        write_reg(CFG_FAILED_LIMIT, fl[7:0]);
        write_reg(CFG_STEP_UP, su[7:0]);
        write_reg(CFG_STEP_DOWN, sd[7:0]);
        write_reg(CFG_OCCURRENCE_CAP, oc[7:0]);
        write_reg(CFG_AGING_CAP, ac[7:0]);
        write_reg(CFG_AGING_LIMIT, al[7:0]);
        @(posedge clk);
    endtask

    // Mostly well-formed traffic on a few busy events, some noise
    task automatic random_words(int count);
        int pick, id;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            id   = ($urandom_range(3) == 0) ? $urandom_range(1, NUM_EVENTS)
                                            : $urandom_range(1, 6);
            if (pick < 50)
                send_word(OP_REPORT, id, rep_t'($urandom_range(3)), 0);
            else if (pick < 63)
                send_word(OP_MAP, id, REP_PASSED,
                          ($urandom_range(7) == 0) ? NUM_SLOTS : $urandom_range(0, 7));
            else if (pick < 75)
                send_word(OP_AGE, 0, REP_PASSED, 0);
            else if (pick < 88)
                send_word(OP_READ, 0, REP_PASSED, $urandom_range(0, 7));
            else
                send_word(op_t'($urandom_range(3)), $urandom_range(63),
                          rep_t'($urandom_range(3)), $urandom_range(31));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: mapping, each report kind, rejects, unmapped report, reads, aging
        send_word(OP_MAP, 1, REP_PASSED, 0);
        send_word(OP_MAP, 2, REP_PASSED, 15);
        send_word(OP_MAP, 32, REP_PASSED, NUM_SLOTS);
        send_word(OP_MAP, 0, REP_PASSED, 3);
        send_word(OP_MAP, 33, REP_PASSED, 3);
        send_word(OP_MAP, 3, REP_PASSED, 17);
        send_word(OP_REPORT, 1, REP_FAILED, 0);
        send_word(OP_REPORT, 1, REP_FAILED, 0);
        send_word(OP_REPORT, 1, REP_PASSED, 0);
        send_word(OP_REPORT, 2, REP_PREFAILED, 0);
        send_word(OP_REPORT, 2, REP_PREPASSED, 0);
        send_word(OP_REPORT, 2, REP_PREPASSED, 0);
        send_word(OP_REPORT, 32, REP_FAILED, 0);
        send_word(OP_REPORT, 63, REP_FAILED, 31);
        send_word(OP_READ, 0, REP_PASSED, 0);
        send_word(OP_READ, 63, REP_PASSED, 15);
        send_word(OP_READ, 0, REP_PASSED, NUM_SLOTS);
        send_word(OP_READ, 0, REP_PASSED, 31);
        send_word(OP_AGE, 0, REP_PASSED, 0);
        send_word(OP_AGE, 0, REP_PASSED, 0);
        send_word(OP_MAP, 1, REP_PASSED, NUM_SLOTS);
        send_word(OP_REPORT, 1, REP_PREFAILED, 0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_all(-128, 127, 127, 128, 255, 255, 1);
                1: write_all(0, 0, 1, 1, 0, 1, 255);
                2: write_all(-4, 4, 3, 2, 3, 2, 2);
                3: write_all(-$urandom_range(128), $urandom_range(127),
                             $urandom_range(1, 127), $urandom_range(1, 128),
                             $urandom, $urandom_range(1, 255), $urandom_range(1, 6));
                4: write_all(-20, 20, 7, 9, 255, 5, 3);
                default: write_all(-128, 1, 64, 128, 1, 255, 40);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 83; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 83; end
                default: begin send_idle_pct = 36; stall_pct = 36; end
            endcase
            if (ph == 4)
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
                hold_request  = 300;
            end
            random_words(255);
            drain();
        end

        if (dtc_sb.errors == 0 && dtc_sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Give up on a hung handshake
    initial
    begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== fault_event_debounce_dtc_status.f =====
src/fedd_pkg.sv
src/fedd_dbnc.sv
src/fedd_slot_unit.sv
src/fault_event_debounce_dtc_status.sv
verif/fault_event_debounce_dtc_status_tb.sv
